>>> sv/vpha_pkg.sv
// ----------------------------------------------------------------------------
// vpha_pkg
// Types, constants and the arctangent table for the heading angle core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vpha_pkg;

  localparam int unsigned COORD_BITS      = 16;
  localparam int unsigned ANGLE_FRAC_BITS = 6;
  localparam int unsigned ANGLE_BITS      = 15;
  localparam int unsigned PROD_BITS       = 2 * COORD_BITS;
  localparam int unsigned SUM_BITS        = PROD_BITS + 2;
  localparam int unsigned DEG_SHIFT       = 16;
  localparam int unsigned CORDIC_ITER     = 22;
  localparam int unsigned XW              = SUM_BITS + DEG_SHIFT + 4;
  localparam int unsigned ZW              = DEG_SHIFT + 10;
  localparam int unsigned RND_SHIFT       = DEG_SHIFT - ANGLE_FRAC_BITS;

  localparam logic [ZW-1:0] DEG90  = ZW'(90) << DEG_SHIFT;
  localparam logic [ZW-1:0] DEG180 = ZW'(180) << DEG_SHIFT;
  localparam logic [ANGLE_BITS-1:0] DEG360 = ANGLE_BITS'(360 << ANGLE_FRAC_BITS);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic signed [COORD_BITS-1:0] a_z;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
    logic signed [COORD_BITS-1:0] b_z;
  } in_t;

  typedef struct packed {
    logic [ANGLE_BITS-1:0] angle_deg;
    logic                  zero_length;
  } out_t;

  typedef struct packed {
    logic vld;
    logic zero;
    logic dneg;
    logic cyneg;
  } side_t;

  typedef struct packed {
    logic signed [SUM_BITS-1:0] d;
    logic signed [SUM_BITS-1:0] cx;
    logic signed [SUM_BITS-1:0] cy;
    logic signed [SUM_BITS-1:0] cz;
  } sums_t;

  function automatic logic signed [ZW-1:0] atan_lut(input int unsigned i);
    logic signed [ZW-1:0] r;
    case (i)
      0:  r = ZW'(2949120);
      1:  r = ZW'(1740967);
      2:  r = ZW'(919879);
      3:  r = ZW'(466945);
      4:  r = ZW'(234379);
      5:  r = ZW'(117304);
      6:  r = ZW'(58666);
      7:  r = ZW'(29335);
      8:  r = ZW'(14668);
      9:  r = ZW'(7334);
      10: r = ZW'(3667);
      11: r = ZW'(1833);
      12: r = ZW'(917);
      13: r = ZW'(458);
      14: r = ZW'(229);
      15: r = ZW'(115);
      16: r = ZW'(57);
      17: r = ZW'(29);
      18: r = ZW'(14);
      19: r = ZW'(7);
      20: r = ZW'(4);
      21: r = ZW'(2);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/vpha_product.sv
// ----------------------------------------------------------------------------
// vpha_product
// Two stages: coordinate products, then dot and cross sums with flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vpha_product (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           vld_i,
  input  wire vpha_pkg::in_t  data_i,
  output vpha_pkg::side_t     side_o,
  output vpha_pkg::sums_t     sums_o
);

  localparam int unsigned PB = vpha_pkg::PROD_BITS;
  localparam int unsigned SB = vpha_pkg::SUM_BITS;

  logic signed [PB-1:0] p_axbx_q, p_ayby_q, p_azbz_q;
  logic signed [PB-1:0] p_aybz_q, p_azby_q, p_azbx_q;
  logic signed [PB-1:0] p_axbz_q, p_axby_q, p_aybx_q;
  logic                 vld1_q, zero1_q;
  logic                 zero_d;
  vpha_pkg::side_t      side_q;
  vpha_pkg::sums_t      sums_q;
  logic signed [SB-1:0] cy_d;

  assign zero_d = ((data_i.a_x == '0) && (data_i.a_y == '0) && (data_i.a_z == '0)) ||
                  ((data_i.b_x == '0) && (data_i.b_y == '0) && (data_i.b_z == '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero1_q  <= zero_d;
      p_axbx_q <= data_i.a_x * data_i.b_x;
      p_ayby_q <= data_i.a_y * data_i.b_y;
      p_azbz_q <= data_i.a_z * data_i.b_z;
      p_aybz_q <= data_i.a_y * data_i.b_z;
      p_azby_q <= data_i.a_z * data_i.b_y;
      p_azbx_q <= data_i.a_z * data_i.b_x;
      p_axbz_q <= data_i.a_x * data_i.b_z;
      p_axby_q <= data_i.a_x * data_i.b_y;
      p_aybx_q <= data_i.a_y * data_i.b_x;
    end
  end

  assign cy_d = SB'(p_azbx_q) - SB'(p_axbz_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q.vld   <= vld1_q;
      side_q.zero  <= zero1_q;
      side_q.dneg  <= (SB'(p_axbx_q) + SB'(p_ayby_q) + SB'(p_azbz_q)) < 0;
      side_q.cyneg <= cy_d < 0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sums_q.d  <= SB'(p_axbx_q) + SB'(p_ayby_q) + SB'(p_azbz_q);
      sums_q.cx <= SB'(p_aybz_q) - SB'(p_azby_q);
      sums_q.cy <= cy_d;
      sums_q.cz <= SB'(p_axby_q) - SB'(p_aybx_q);
    end
  end

  assign side_o = side_q;
  assign sums_o = sums_q;

endmodule

`default_nettype wire

>>> sv/vpha_cordic.sv
// ----------------------------------------------------------------------------
// vpha_cordic
// Vectoring cordic, one micro-rotation per register stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vpha_cordic (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               en_i,
  input  wire logic signed [vpha_pkg::XW-1:0]     x_i,
  input  wire logic signed [vpha_pkg::XW-1:0]     y_i,
  input  wire vpha_pkg::side_t                    side_i,
  output logic signed [vpha_pkg::XW-1:0]          x_o,
  output logic signed [vpha_pkg::ZW-1:0]          z_o,
  output vpha_pkg::side_t                         side_o
);

  localparam int unsigned N  = vpha_pkg::CORDIC_ITER;
  localparam int unsigned XW = vpha_pkg::XW;
  localparam int unsigned ZW = vpha_pkg::ZW;

  logic signed [XW-1:0] x_s [N+1];
  logic signed [XW-1:0] y_s [N+1];
  logic signed [ZW-1:0] z_s [N+1];
  vpha_pkg::side_t      side_s [N+1];

  assign x_s[0]    = x_i;
  assign y_s[0]    = y_i;
  assign z_s[0]    = '0;
  assign side_s[0] = side_i;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [XW-1:0] xs, ys;
    assign xs = x_s[i] >>> i;
    assign ys = y_s[i] >>> i;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (y_s[i] >= 0) begin
          x_s[i+1] <= x_s[i] + ys;
          y_s[i+1] <= y_s[i] - xs;
          z_s[i+1] <= z_s[i] + vpha_pkg::atan_lut(i);
        end else begin
          x_s[i+1] <= x_s[i] - ys;
          y_s[i+1] <= y_s[i] + xs;
          z_s[i+1] <= z_s[i] - vpha_pkg::atan_lut(i);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_s[i+1] <= '0;
      end else if (en_i) begin
        side_s[i+1] <= side_s[i];
      end
    end
  end

  assign x_o    = x_s[N];
  assign z_o    = z_s[N];
  assign side_o = side_s[N];

endmodule

`default_nettype wire

>>> sv/vpha_finish.sv
// ----------------------------------------------------------------------------
// vpha_finish
// Quadrant offset, clamp, rounding, full-circle fold and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vpha_finish (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            en_i,
  input  wire logic signed [vpha_pkg::ZW-1:0]  z_i,
  input  wire vpha_pkg::side_t                 side_i,
  output logic                                 vld_o,
  output vpha_pkg::out_t                       data_o
);

  localparam int unsigned ZW = vpha_pkg::ZW;
  localparam int unsigned AB = vpha_pkg::ANGLE_BITS;

  logic signed [ZW-1:0] z_off;
  logic        [ZW-1:0] z_clamp;
  logic        [ZW-1:0] z_rnd;
  logic        [AB-1:0] q;
  vpha_pkg::out_t       data_d, data_q;
  logic                 vld_q;

  always_comb begin
    z_off = side_i.dneg ? z_i + $signed(vpha_pkg::DEG90) : z_i;
    if (z_off < 0) begin
      z_clamp = '0;
    end else if (z_off > $signed(vpha_pkg::DEG180)) begin
      z_clamp = vpha_pkg::DEG180;
    end else begin
      z_clamp = z_off;
    end
    z_rnd = (z_clamp + (ZW'(1) << (vpha_pkg::RND_SHIFT - 1))) >> vpha_pkg::RND_SHIFT;
    q     = z_rnd[AB-1:0];
    if (side_i.zero) begin
      data_d.angle_deg   = '0;
      data_d.zero_length = 1'b1;
    end else begin
      data_d.angle_deg   = side_i.cyneg ? vpha_pkg::DEG360 - q : q;
      data_d.zero_length = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= side_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule

`default_nettype wire

>>> sv/vector_pair_heading_angle_core.sv
// stages from input transfer to result: 2 product/sum stages, 3 cordic passes
// of 22 stages each, 1 output stage
// throughput: one vector pair per cycle; a stalled output holds the whole pipe
// reset clears all valid bits; datapath registers are not reset
// ----------------------------------------------------------------------------
// vector_pair_heading_angle_core
// Full-circle angle between two 3d vectors, degrees with 6 fraction bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vector_pair_heading_angle_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire vpha_pkg::in_t    in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output vpha_pkg::out_t        out_data_o
);

  localparam int unsigned XW = vpha_pkg::XW;
  localparam int unsigned ZW = vpha_pkg::ZW;
  localparam int unsigned SB = vpha_pkg::SUM_BITS;

  logic                 en;
  vpha_pkg::side_t      p_side, s1_side, s2_side, s3_side;
  vpha_pkg::sums_t      sums;
  logic signed [SB-1:0] d_abs, cx_abs, cy_abs, cz_abs;
  logic signed [XW-1:0] d_x, cx_x, cy_x, cz_x;
  logic signed [XW-1:0] m1, mz, dm1, r, dm, x3, y3;
  logic signed [ZW-1:0] z3;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  vpha_product u_prod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_valid_i),
    .data_i (in_data_i),
    .side_o (p_side),
    .sums_o (sums)
  );

  assign d_abs  = sums.d  < 0 ? -sums.d  : sums.d;
  assign cx_abs = sums.cx < 0 ? -sums.cx : sums.cx;
  assign cy_abs = sums.cy < 0 ? -sums.cy : sums.cy;
  assign cz_abs = sums.cz < 0 ? -sums.cz : sums.cz;
  assign d_x  = XW'(d_abs)  <<< vpha_pkg::DEG_SHIFT;
  assign cx_x = XW'(cx_abs) <<< vpha_pkg::DEG_SHIFT;
  assign cy_x = XW'(cy_abs) <<< vpha_pkg::DEG_SHIFT;
  assign cz_x = XW'(cz_abs) <<< vpha_pkg::DEG_SHIFT;

  vpha_cordic u_c1a (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
    .x_i (cx_x), .y_i (cy_x), .side_i (p_side),
    .x_o (m1), .z_o (), .side_o (s1_side)
  );

  vpha_cordic u_c1b (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
    .x_i (cz_x), .y_i ('0), .side_i (p_side),
    .x_o (mz), .z_o (), .side_o ()
  );

  vpha_cordic u_c1c (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
    .x_i (d_x), .y_i ('0), .side_i (p_side),
    .x_o (dm1), .z_o (), .side_o ()
  );

  vpha_cordic u_c2a (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
    .x_i (m1), .y_i (mz), .side_i (s1_side),
    .x_o (r), .z_o (), .side_o (s2_side)
  );

  vpha_cordic u_c2b (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
    .x_i (dm1), .y_i ('0), .side_i (s1_side),
    .x_o (dm), .z_o (), .side_o ()
  );

  assign x3 = s2_side.dneg ? r  : dm;
  assign y3 = s2_side.dneg ? dm : r;

  vpha_cordic u_c3 (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
    .x_i (x3), .y_i (y3), .side_i (s2_side),
    .x_o (), .z_o (z3), .side_o (s3_side)
  );

  vpha_finish u_fin (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .z_i    (z3),
    .side_i (s3_side),
    .vld_o  (out_valid_o),
    .data_o (out_data_o)
  );

  a_ready_tracks_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow output stall");

  a_zero_gives_zero_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.zero_length |-> out_data_o.angle_deg == '0)
    else $error("zero-length result with nonzero angle");

  a_angle_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.angle_deg <= vpha_pkg::DEG360)
    else $error("angle beyond full circle");

  a_stall_holds_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(s3_side) && $stable(p_side))
    else $error("pipeline moved during output stall");

endmodule

`default_nettype wire

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the heading angle core against a behavioral predictor with random
// handshake gaps on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class angle_scoreboard;
  vpha_pkg::out_t pending_q[$];
  int unsigned    errors;

  function new();
    errors = 0;
  endfunction

  static function longint fdiv(longint v, int unsigned s);
    if (v >= 0) return v >>> s;
    return -(((-v) - 1) >>> s) - 1;
  endfunction

  static function longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  static function longint rotate(longint x, longint y, output longint ang);
    longint xs, ys;
    ang = 0;
    for (int i = 0; i < vpha_pkg::CORDIC_ITER; i++) begin
      xs = fdiv(x, i);
      ys = fdiv(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; ang += longint'(vpha_pkg::atan_lut(i));
      end else begin
        x -= ys; y += xs; ang -= longint'(vpha_pkg::atan_lut(i));
      end
    end
    return x;
  endfunction

  static function vpha_pkg::out_t heading(vpha_pkg::in_t v);
    vpha_pkg::out_t r;
    longint ax, ay, az, bx, by, bz, d, cx, cy, cz, m1, mz, rr, dm, z, tmp;
    longint unsigned q;
    ax = v.a_x; ay = v.a_y; az = v.a_z;
    bx = v.b_x; by = v.b_y; bz = v.b_z;
    r = '0;
    if ((ax == 0 && ay == 0 && az == 0) || (bx == 0 && by == 0 && bz == 0)) begin
      r.zero_length = 1'b1;
      return r;
    end
    d  = ax * bx + ay * by + az * bz;
    cx = ay * bz - az * by;
    cy = az * bx - ax * bz;
    cz = ax * by - ay * bx;
    m1 = rotate(mag(cx) * 65536, mag(cy) * 65536, tmp);
    mz = rotate(mag(cz) * 65536, 0, tmp);
    rr = rotate(m1, mz, tmp);
    dm = rotate(rotate(mag(d) * 65536, 0, tmp), 0, tmp);
    if (d >= 0) begin
      void'(rotate(dm, rr, z));
    end else begin
      void'(rotate(rr, dm, z));
      z += longint'(90) << 16;
    end
    if (z < 0) z = 0;
    if (z > (longint'(180) << 16)) z = longint'(180) << 16;
    q = (longint'(z) + (64'd1 << 9)) >> 10;
    if (cy < 0) q = (64'd360 << 6) - q;
    r.angle_deg = q[14:0];
    return r;
  endfunction

  function void note_pair(vpha_pkg::in_t v);
    pending_q.push_back(heading(v));
  endfunction

  function void check_angle(vpha_pkg::out_t got);
    vpha_pkg::out_t exp_r;
    if (pending_q.size() == 0) begin
      $error("unexpected result angle_deg=%0d zero_length=%0d",
             got.angle_deg, got.zero_length);
      errors++;
      return;
    end
    exp_r = pending_q.pop_front();
    if (got.angle_deg !== exp_r.angle_deg) begin
      $error("angle_deg expected %0d actual %0d", exp_r.angle_deg, got.angle_deg);
      errors++;
    end
    if (got.zero_length !== exp_r.zero_length) begin
      $error("zero_length expected %0d actual %0d",
             exp_r.zero_length, got.zero_length);
      errors++;
    end
  endfunction
endclass

module tb;

  localparam int unsigned LATENCY = 69;
  localparam int unsigned WDOG    = 20000;

  logic clk = 1'b0, rst_n = 1'b0;
  logic in_valid = 1'b0, in_ready, out_valid, out_ready = 1'b0;
  vpha_pkg::in_t  in_data = '0;
  vpha_pkg::out_t out_data;
  int unsigned send_idle = 0, recv_idle = 0, stall_cnt = 0;
  angle_scoreboard sb = new();

  always #5 clk = ~clk;

  vector_pair_heading_angle_core i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // sample transfers
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_pair(in_data);
      if (out_valid && out_ready) sb.check_angle(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= WDOG) begin
        $display("vector_pair_heading_angle_core regression: fail");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_pair(vpha_pkg::in_t v);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(int'($urandom_range(6)) - 3);
      3: return 16'(int'($urandom_range(400)) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic vpha_pkg::in_t rand_pair();
    vpha_pkg::in_t v;
    v = {rand_coord(), rand_coord(), rand_coord(),
         rand_coord(), rand_coord(), rand_coord()};
    if ($urandom_range(19) == 0) {v.a_x, v.a_y, v.a_z} = '0;
    if ($urandom_range(19) == 0) {v.b_x, v.b_y, v.b_z} = '0;
    if ($urandom_range(9) == 0) {v.b_x, v.b_y, v.b_z} = {v.a_x, v.a_y, v.a_z};
    return v;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    vpha_pkg::in_t dir_q[$];
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    dir_q = '{
      '{16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd2, 16'sd3},
      '{16'sd1, 16'sd2, 16'sd3, 16'sd0, 16'sd0, 16'sd0},
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
      '{16'sd1, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0},
      '{16'sd1, 16'sd0, 16'sd0, -16'sd1, 16'sd0, 16'sd0},
      '{16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1},
      '{16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd1},
      '{16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd0, 16'sd0},
      '{16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0},
      '{16'sd1000, 16'sd0, 16'sd0, 16'sd1000, 16'sd0, -16'sd1},
      '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768},
      '{-16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 16'sd32767},
      '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767},
      '{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768},
      '{-16'sd32768, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd32767},
      '{16'sd3, 16'sd4, 16'sd0, -16'sd4, 16'sd3, 16'sd0},
      '{16'sd5, 16'sd1, 16'sd7, 16'sd5, 16'sd1, 16'sd7}
    };
    @(negedge clk);
    foreach (dir_q[i]) send_pair(dir_q[i]);
    wait_drained();
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 34 : (ph == 1) ? 79 : 0;
      recv_idle = (ph == 0) ? 79 : (ph == 1) ? 34 : 0;
      for (int n = 0; n < 300; n++) begin
        send_pair(rand_pair());
        if (n == 150 && ph == 1) wait_drained();
      end
    end
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("vector_pair_heading_angle_core regression: pass");
    end else begin
      $display("vector_pair_heading_angle_core regression: fail");
    end
    $finish;
  end
endmodule
